@@ hw/rtl/sida_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sida_pkg;

   localparam int CHAR_BITS = 7;
   localparam int BCD_BITS  = 4;

   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'd45;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'd48;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 7'd57;

   localparam logic [BCD_BITS-1:0] DIGIT_ADJ_MIN = 4'd5;
   localparam logic [BCD_BITS-1:0] DIGIT_ADJ_ADD = 4'd3;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } dabble_ctrl_type;

endpackage

`default_nettype wire

@@ hw/rtl/sida_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface sida_req_if #(
   parameter int VALUE_BITS = 32
);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sida_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [sida_pkg::CHAR_BITS-1:0] char_code;
   logic                           last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sida_dabble.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sida_dabble #(
   parameter int VALUE_BITS = 32,
   parameter int MAX_DIGITS = 10
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire sida_pkg::dabble_ctrl_type              ctrl,
   input  wire logic [VALUE_BITS-1:0]                  value,
   output logic                                        done,
   output logic [MAX_DIGITS*sida_pkg::BCD_BITS-1:0]    bcd,
   output logic                                        overflow
);

   localparam int BCD_W = MAX_DIGITS * sida_pkg::BCD_BITS;
   localparam int CNT_W = $clog2(VALUE_BITS);

   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic                  ovf_ff, ovf_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [BCD_W-1:0]      adjusted;
   logic [VALUE_BITS-1:0] magnitude;

   // two's complement magnitude, most negative value included
   assign magnitude = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;

   always_comb begin
      logic [sida_pkg::BCD_BITS-1:0] digit;
      digit = '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         digit = bcd_ff[i*sida_pkg::BCD_BITS +: sida_pkg::BCD_BITS];
         adjusted[i*sida_pkg::BCD_BITS +: sida_pkg::BCD_BITS] =
            (digit >= sida_pkg::DIGIT_ADJ_MIN) ? digit + sida_pkg::DIGIT_ADJ_ADD : digit;
      end
   end

   always_comb begin
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      ovf_in = ovf_ff;
      cnt_in = cnt_ff;
      if (ctrl.load) begin
         mag_in = magnitude;
         bcd_in = '0;
         ovf_in = 1'b0;
         cnt_in = '0;
      end else if (ctrl.step) begin
         mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
         bcd_in = {adjusted[BCD_W-2:0], mag_ff[VALUE_BITS-1]};
         ovf_in = ovf_ff | adjusted[BCD_W-1];
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

   assign done     = (cnt_ff == CNT_W'(VALUE_BITS - 1));
   assign bcd      = bcd_ff;
   assign overflow = ovf_ff;

endmodule

`default_nettype wire

@@ hw/rtl/signed_int_to_decimal_ascii_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Operation: one transaction runs VALUE_BITS shift-and-add-3 steps, then the characters
// leave one per cycle while the result side accepts them, leading zero digits skipped
// at one per cycle; a negative value first sends a minus sign. A new value is taken only
// once the sequencer is idle again after the last character. All steps use the single
// digit-adjust-and-shift unit, which serves each input bit.
// Reset: synchronous, active high; clears the sequencer and the output valid.
module signed_int_to_decimal_ascii_top #(
   parameter int VALUE_BITS = 32,
   parameter int MAX_DIGITS = 10
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sida_req_if.sink   req_bus,
   sida_rsp_if.source rsp_bus
);

   localparam int BCD_W = MAX_DIGITS * sida_pkg::BCD_BITS;
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   sida_pkg::state_type       state_ff, state_in;
   sida_pkg::dabble_ctrl_type dab_ctrl;
   logic                      dab_done;
   logic [BCD_W-1:0]          dab_bcd;
   logic                      dab_ovf;

   logic [IDX_W-1:0]                idx_ff, idx_in;
   logic                            lead_ff, lead_in;
   logic                            sign_ff, sign_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [sida_pkg::CHAR_BITS-1:0]  char_ff, char_in;
   logic                            last_ff, last_in;
   logic                            accept;
   logic                            slot_free;
   logic [sida_pkg::BCD_BITS-1:0]   digit;

   assign req_bus.ready = (state_ff == sida_pkg::ST_IDLE);
   assign accept        = req_bus.valid & req_bus.ready;
   assign slot_free     = ~rsp_valid_ff | rsp_bus.ready;
   assign digit         = dab_bcd[idx_ff*sida_pkg::BCD_BITS +: sida_pkg::BCD_BITS];

   assign dab_ctrl.load = accept;
   assign dab_ctrl.step = (state_ff == sida_pkg::ST_CONV);

   sida_dabble #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dabble (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (dab_ctrl),
      .value    (req_bus.value),
      .done     (dab_done),
      .bcd      (dab_bcd),
      .overflow (dab_ovf)
   );

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      lead_in      = lead_ff;
      sign_in      = sign_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      char_in      = char_ff;
      last_in      = last_ff;
      case (state_ff)
         sida_pkg::ST_IDLE: begin
            if (accept) begin
               sign_in  = req_bus.value[VALUE_BITS-1];
               state_in = sida_pkg::ST_CONV;
            end
         end
         sida_pkg::ST_CONV: begin
            if (dab_done) begin
               idx_in   = IDX_W'(MAX_DIGITS - 1);
               lead_in  = 1'b1;
               state_in = sida_pkg::ST_EMIT;
            end
         end
         sida_pkg::ST_EMIT: begin
            if (lead_ff && !sign_ff && !dab_ovf && digit == '0 && idx_ff != '0) begin
               // drop leading zero
               idx_in = idx_ff - IDX_W'(1);
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (sign_ff) begin
                  char_in = sida_pkg::CHAR_MINUS;
                  last_in = 1'b0;
                  sign_in = 1'b0;
               end else begin
                  char_in = sida_pkg::CHAR_ZERO + sida_pkg::CHAR_BITS'(digit);
                  last_in = (idx_ff == '0);
                  lead_in = 1'b0;
                  if (idx_ff == '0) begin
                     state_in = sida_pkg::ST_IDLE;
                  end else begin
                     idx_in = idx_ff - IDX_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = sida_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sida_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sign_ff      <= 1'b0;
         lead_ff      <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sign_ff      <= sign_in;
         lead_ff      <= lead_in;
         idx_ff       <= idx_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.char_code = char_ff;
   assign rsp_bus.last_char = last_ff;

`ifndef NO_ASSERTIONS
   a_accept_starts_conv : assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == sida_pkg::ST_CONV)
      else $error("transaction accepted without starting conversion");

   a_last_ends_item : assert property (@(posedge clock) disable iff (reset)
      (state_ff == sida_pkg::ST_EMIT && rsp_valid_in && !rsp_valid_ff && last_in)
      |=> state_ff == sida_pkg::ST_IDLE)
      else $error("last character sent but sequencer still busy");

   a_char_legal : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (char_ff == sida_pkg::CHAR_MINUS ||
                        (char_ff >= sida_pkg::CHAR_ZERO && char_ff <= sida_pkg::CHAR_NINE)))
      else $error("illegal character code");

   a_minus_not_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && char_ff == sida_pkg::CHAR_MINUS) |-> !last_ff)
      else $error("minus sign flagged as last character");
`endif

endmodule

`default_nettype wire
